// File: hdl/cdt_pkg.sv
// Shared constants, codes and structs for the confidence drift trigger.
// Depends on nothing; the design files refer to it by scoped names, the testbench files import it.
package cdt_pkg;

   // Correction ring
   localparam int RING_DEPTH = 16;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int RING_CW    = $clog2(RING_DEPTH + 1);

   // Field widths
   localparam int CONF_W     = 17;
   localparam int INTERVAL_W = 16;
   localparam int COUNT_W    = 8;
   localparam int TASK_IN_W  = 8;
   localparam int TASK_W     = 2;
   localparam int LABEL_W    = 8;
   localparam int PENDING_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int NUM_LANES  = 3;

   // Constants of the drift rule
   localparam logic [CONF_W-1:0]     AVG_RESET   = 17'd65536;
   localparam logic [COUNT_W-1:0]    COUNT_MAX   = 8'd255;
   localparam logic [COUNT_W-1:0]    MIN_WINDOWS = 8'd10;
   localparam logic [COUNT_W-1:0]    HOLD_RUN    = 8'd3;
   localparam logic [INTERVAL_W-1:0] WST_MAX     = 16'hFFFF;
   localparam logic [TASK_IN_W-1:0]  TASK_MAX    = 8'd2;

   // Operation codes
   typedef logic [1:0] op_type;
   localparam op_type OP_WINDOW = 2'd0;
   localparam op_type OP_ADD    = 2'd1;
   localparam op_type OP_POP    = 2'd2;

   // Trigger reasons
   typedef logic [1:0] reason_type;
   localparam reason_type REASON_NONE     = 2'd0;
   localparam reason_type REASON_USER     = 2'd1;
   localparam reason_type REASON_DRIFT    = 2'd2;
   localparam reason_type REASON_PERIODIC = 2'd3;

   // Register indexes
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_ALPHA     = 2'd0;
   localparam csr_idx_type REG_THRESHOLD = 2'd1;
   localparam csr_idx_type REG_INTERVAL  = 2'd2;

   // Lane state after the current request
   typedef struct packed {
      logic flag;
      logic held;
   } lane_status_type;

   // Ring outcome of the current request
   typedef struct packed {
      logic                 accepted;
      logic [TASK_W-1:0]    popped_task;
      logic [LABEL_W-1:0]   popped_label;
      logic                 nonempty;
      logic [PENDING_W-1:0] pending;
   } ring_status_type;

   // One result
   typedef struct packed {
      logic                 accepted;
      logic [TASK_W-1:0]    popped_task;
      logic [LABEL_W-1:0]   popped_label;
      logic                 train_request;
      reason_type           trigger_reason;
      logic [NUM_LANES-1:0] drift_flags;
      logic [PENDING_W-1:0] pending_count;
   } rsp_type;

endpackage

// File: hdl/cdt_channels.sv
// Valid/ready channel interfaces for request, result and register write.
// Depends on cdt_pkg for field widths.
interface cdt_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    op;
   logic                          window_valid;
   logic [cdt_pkg::CONF_W-1:0]    activity_conf;
   logic [cdt_pkg::CONF_W-1:0]    stress_conf;
   logic [cdt_pkg::CONF_W-1:0]    rhythm_conf;
   logic [cdt_pkg::TASK_IN_W-1:0] corr_task;
   logic [cdt_pkg::LABEL_W-1:0]   corr_label;

   modport source (output valid, op, window_valid, activity_conf, stress_conf,
                   rhythm_conf, corr_task, corr_label, input ready);
   modport sink   (input valid, op, window_valid, activity_conf, stress_conf,
                   rhythm_conf, corr_task, corr_label, output ready);
endinterface

interface cdt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic [cdt_pkg::TASK_W-1:0]    popped_task;
   logic [cdt_pkg::LABEL_W-1:0]   popped_label;
   logic                          train_request;
   logic [1:0]                    trigger_reason;
   logic [cdt_pkg::NUM_LANES-1:0] drift_flags;
   logic [cdt_pkg::PENDING_W-1:0] pending_count;

   modport source (output valid, accepted, popped_task, popped_label, train_request,
                   trigger_reason, drift_flags, pending_count, input ready);
   modport sink   (input valid, accepted, popped_task, popped_label, train_request,
                   trigger_reason, drift_flags, pending_count, output ready);
endinterface

interface cdt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cdt_pkg::CSR_IDX_W-1:0] index;
   logic [cdt_pkg::CONF_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/confidence_drift_trigger.sv
// Top level of the confidence drift trigger: registers, three lanes, ring,
// merge stage and a two-entry result buffer. Depends on cdt_pkg, the channel
// interfaces, cdt_lane, cdt_ring and cdt_merge.
//
//   channel   direction  handshake    carries
//   req_ch    in         valid/ready  op, window fields, correction fields
//   rsp_ch    out        valid/ready  accepted, popped entry, trigger, flags, count
//   csr_ch    in         valid/ready  register index, write data (always ready)
//
// One request per cycle while the skid entry is free; its result is registered in the
// output register, or in the skid entry while the output is stalled. The rate is set
// by the combinational multiply-add feedback of each lane and the one write / one read port of the ring memory.
// Synchronous reset clears all counters, averages and pointers; the ring
// contents are not cleared and there is no clearing pass.
// A stalled result is held in the output register and a second request is
// absorbed by the skid entry; requests stop only while that entry is full.
module confidence_drift_trigger (
   input  logic      clock,
   input  logic      reset,
   cdt_req_if.sink   req_ch,
   cdt_rsp_if.source rsp_ch,
   cdt_csr_if.sink   csr_ch
);

   // Configuration registers
   logic [cdt_pkg::CONF_W-1:0]     alpha_ff;
   logic [cdt_pkg::CONF_W-1:0]     threshold_ff;
   logic [cdt_pkg::INTERVAL_W-1:0] interval_ff;

   // Request decode
   logic accept, window_update, add_req, pop_req;
   logic [cdt_pkg::CONF_W-1:0] conf [cdt_pkg::NUM_LANES];

   cdt_pkg::lane_status_type lane_status [cdt_pkg::NUM_LANES];
   cdt_pkg::ring_status_type ring_status;
   cdt_pkg::rsp_type         result;

   // Result buffer: output register plus skid entry
   cdt_pkg::rsp_type out_ff, skid_ff;
   logic             out_valid_ff, skid_valid_ff;
   logic             take;

   assign csr_ch.ready = 1'b1;

   // Take register writes; ignore indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= 17'd6554;
         threshold_ff <= 17'd39322;
         interval_ff  <= 16'd100;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            cdt_pkg::REG_ALPHA:     alpha_ff     <= csr_ch.data;
            cdt_pkg::REG_THRESHOLD: threshold_ff <= csr_ch.data;
            cdt_pkg::REG_INTERVAL:  interval_ff  <= csr_ch.data[cdt_pkg::INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Accept a request whenever the skid entry is free
   assign req_ch.ready  = !skid_valid_ff;
   assign accept        = req_ch.valid && !skid_valid_ff;
   assign window_update = accept && (req_ch.op == cdt_pkg::OP_WINDOW) && req_ch.window_valid;
   assign add_req       = accept && (req_ch.op == cdt_pkg::OP_ADD);
   assign pop_req       = accept && (req_ch.op == cdt_pkg::OP_POP);

   assign conf[0] = req_ch.activity_conf;
   assign conf[1] = req_ch.stress_conf;
   assign conf[2] = req_ch.rhythm_conf;

   // One lane per task, all updated by the same window
   for (genvar t = 0; t < cdt_pkg::NUM_LANES; t++) begin : g_lane
      cdt_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .update    (window_update),
         .conf      (conf[t]),
         .alpha     (alpha_ff),
         .threshold (threshold_ff),
         .status    (lane_status[t])
      );
   end

   cdt_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .add_req    (add_req),
      .pop_req    (pop_req),
      .corr_task  (req_ch.corr_task),
      .corr_label (req_ch.corr_label),
      .status     (ring_status)
   );

   cdt_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .op            (req_ch.op),
      .window_update (window_update),
      .interval      (interval_ff),
      .lanes         (lane_status),
      .ring          (ring_status),
      .result        (result)
   );

   assign take = out_valid_ff && rsp_ch.ready;

   // Advance the buffer: refill from skid first, else load the new result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.accepted       = out_ff.accepted;
   assign rsp_ch.popped_task    = out_ff.popped_task;
   assign rsp_ch.popped_label   = out_ff.popped_label;
   assign rsp_ch.train_request  = out_ff.train_request;
   assign rsp_ch.trigger_reason = out_ff.trigger_reason;
   assign rsp_ch.drift_flags    = out_ff.drift_flags;
   assign rsp_ch.pending_count  = out_ff.pending_count;

endmodule

// File: hdl/cdt_lane.sv
// One confidence lane: moving average, window count and drift run.
// Depends on cdt_pkg.
module cdt_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       update,
   input  logic [cdt_pkg::CONF_W-1:0] conf,
   input  logic [cdt_pkg::CONF_W-1:0] alpha,
   input  logic [cdt_pkg::CONF_W-1:0] threshold,
   output cdt_pkg::lane_status_type   status
);

   logic [cdt_pkg::CONF_W-1:0]  avg_ff, avg_in;
   logic [cdt_pkg::COUNT_W-1:0] seen_ff, seen_in;
   logic [cdt_pkg::COUNT_W-1:0] run_ff, run_in;
   logic                        flag_ff, flag_in;

   logic signed [cdt_pkg::CONF_W:0]     diff;
   logic signed [2*cdt_pkg::CONF_W+1:0] prod;
   logic signed [cdt_pkg::CONF_W+2:0]   step;
   logic signed [cdt_pkg::CONF_W+3:0]   sum;
   logic [cdt_pkg::CONF_W-1:0]          avg_new;
   logic [cdt_pkg::COUNT_W-1:0]         seen_new;

   always_comb begin
      diff = $signed({1'b0, conf}) - $signed({1'b0, avg_ff});
      prod = $signed({1'b0, alpha}) * diff;
      // floor shift by 16: keep the upper bits
      step = $signed(prod[2*cdt_pkg::CONF_W+1:16]);
      sum  = $signed({4'b0, avg_ff}) + $signed({step[cdt_pkg::CONF_W+2], step});
      if (sum < 0) begin
         avg_new = '0;
      end else if (sum > $signed({4'b0, {cdt_pkg::CONF_W{1'b1}}})) begin
         avg_new = {cdt_pkg::CONF_W{1'b1}};
      end else begin
         avg_new = sum[cdt_pkg::CONF_W-1:0];
      end
      seen_new = (seen_ff == cdt_pkg::COUNT_MAX) ? seen_ff : seen_ff + 1'b1;

      avg_in  = avg_ff;
      seen_in = seen_ff;
      flag_in = flag_ff;
      run_in  = run_ff;
      if (update) begin
         avg_in  = avg_new;
         seen_in = seen_new;
         if (avg_new < threshold && seen_new > cdt_pkg::MIN_WINDOWS) begin
            flag_in = 1'b1;
            run_in  = (run_ff == cdt_pkg::COUNT_MAX) ? run_ff : run_ff + 1'b1;
         end else begin
            flag_in = 1'b0;
            run_in  = '0;
         end
      end
      status.flag = flag_in;
      status.held = flag_in && (run_in >= cdt_pkg::HOLD_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff  <= cdt_pkg::AVG_RESET;
         seen_ff <= '0;
         flag_ff <= 1'b0;
         run_ff  <= '0;
      end else begin
         avg_ff  <= avg_in;
         seen_ff <= seen_in;
         flag_ff <= flag_in;
         run_ff  <= run_in;
      end
   end

endmodule

// File: hdl/cdt_ring.sv
// Correction ring: task/label memory with pointers and fill count.
// Depends on cdt_pkg.
module cdt_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          add_req,
   input  logic                          pop_req,
   input  logic [cdt_pkg::TASK_IN_W-1:0] corr_task,
   input  logic [cdt_pkg::LABEL_W-1:0]   corr_label,
   output cdt_pkg::ring_status_type      status
);

   logic [cdt_pkg::TASK_W-1:0]  ring_task_ff  [cdt_pkg::RING_DEPTH];
   logic [cdt_pkg::LABEL_W-1:0] ring_label_ff [cdt_pkg::RING_DEPTH];
   logic [cdt_pkg::TASK_W-1:0]  head_task_ff;
   logic [cdt_pkg::LABEL_W-1:0] head_label_ff;

   logic [cdt_pkg::RING_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cdt_pkg::RING_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cdt_pkg::RING_CW-1:0] count_ff, count_in;

   logic                                  do_add, do_pop, full, bypass;
   logic [cdt_pkg::RING_AW-1:0]           wr_ptr_inc, rd_ptr_inc;
   logic [cdt_pkg::RING_CW+cdt_pkg::PENDING_W-1:0] count_ext;

   always_comb begin
      do_add = add_req && (corr_task <= cdt_pkg::TASK_MAX);
      do_pop = pop_req && (count_ff != '0);
      full   = (count_ff == cdt_pkg::RING_CW'(cdt_pkg::RING_DEPTH));
      wr_ptr_inc = (wr_ptr_ff == cdt_pkg::RING_AW'(cdt_pkg::RING_DEPTH - 1)) ?
                   '0 : wr_ptr_ff + 1'b1;
      rd_ptr_inc = (rd_ptr_ff == cdt_pkg::RING_AW'(cdt_pkg::RING_DEPTH - 1)) ?
                   '0 : rd_ptr_ff + 1'b1;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_add) begin
         wr_ptr_in = wr_ptr_inc;
         if (full) begin
            rd_ptr_in = rd_ptr_inc;   // drop the oldest entry
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (do_pop) begin
         rd_ptr_in = rd_ptr_inc;
         count_in  = count_ff - 1'b1;
      end
      // head register follows the new read pointer; forward a same-slot write
      bypass = do_add && (wr_ptr_ff == rd_ptr_in);

      count_ext           = {{cdt_pkg::PENDING_W{1'b0}}, count_in};
      status.accepted     = do_add || do_pop;
      status.popped_task  = do_pop ? head_task_ff  : '0;
      status.popped_label = do_pop ? head_label_ff : '0;
      status.nonempty     = (count_in != '0);
      status.pending      = count_ext[cdt_pkg::PENDING_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (do_add) begin
         ring_task_ff[wr_ptr_ff]  <= corr_task[cdt_pkg::TASK_W-1:0];
         ring_label_ff[wr_ptr_ff] <= corr_label;
      end
      if (bypass) begin
         head_task_ff  <= corr_task[cdt_pkg::TASK_W-1:0];
         head_label_ff <= corr_label;
      end else begin
         head_task_ff  <= ring_task_ff[rd_ptr_in];
         head_label_ff <= ring_label_ff[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/cdt_merge.sv
// Merge stage: combines lane and ring outcomes into one result and keeps
// the window-since-training counter. Depends on cdt_pkg.
module cdt_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          op,
   input  logic                                window_update,
   input  logic [cdt_pkg::INTERVAL_W-1:0]      interval,
   input  cdt_pkg::lane_status_type            lanes [cdt_pkg::NUM_LANES],
   input  cdt_pkg::ring_status_type            ring,
   output cdt_pkg::rsp_type                    result
);

   logic [cdt_pkg::INTERVAL_W-1:0] wst_ff, wst_in;
   logic                           any_held;
   cdt_pkg::reason_type            reason;

   always_comb begin
      wst_in = (window_update && wst_ff != cdt_pkg::WST_MAX) ? wst_ff + 1'b1 : wst_ff;

      any_held = 1'b0;
      for (int t = 0; t < cdt_pkg::NUM_LANES; t++) begin
         any_held = any_held | lanes[t].held;
         result.drift_flags[t] = lanes[t].flag;
      end

      // corrections first, then held drift, then the periodic check
      if (ring.nonempty) begin
         reason = cdt_pkg::REASON_USER;
      end else if (any_held) begin
         reason = cdt_pkg::REASON_DRIFT;
      end else if (wst_in >= interval && ring.nonempty) begin
         reason = cdt_pkg::REASON_PERIODIC;
      end else begin
         reason = cdt_pkg::REASON_NONE;
      end

      unique case (op)
         cdt_pkg::OP_WINDOW: result.accepted = 1'b1;
         cdt_pkg::OP_ADD,
         cdt_pkg::OP_POP:    result.accepted = ring.accepted;
         default:            result.accepted = 1'b0;
      endcase
      result.popped_task    = ring.popped_task;
      result.popped_label   = ring.popped_label;
      result.trigger_reason = reason;
      result.train_request  = (reason != cdt_pkg::REASON_NONE);
      result.pending_count  = ring.pending;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wst_ff <= '0;
      end else begin
         wst_ff <= wst_in;
      end
   end

endmodule

// File: hdl/cdt_checker.sv
// Port-level checks on the result channel of the drift trigger, and the
// bind that attaches them. Depends on cdt_pkg and confidence_drift_trigger.
module cdt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          accepted,
   input logic [cdt_pkg::TASK_W-1:0]    popped_task,
   input logic [cdt_pkg::LABEL_W-1:0]   popped_label,
   input logic                          train_request,
   input logic [1:0]                    trigger_reason,
   input logic [cdt_pkg::PENDING_W-1:0] pending_count
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(accepted) &&
      $stable(popped_task) && $stable(popped_label) && $stable(trigger_reason) &&
      $stable(pending_count))
      else $error("stalled result changed");

   // Request flag and reason agree; the periodic reason never wins
   a_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (train_request == (trigger_reason != cdt_pkg::REASON_NONE)) &&
      (trigger_reason != cdt_pkg::REASON_PERIODIC))
      else $error("trigger reason inconsistent");

   // Pending corrections always give the user reason
   a_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (pending_count != '0) |-> trigger_reason == cdt_pkg::REASON_USER)
      else $error("pending corrections without user trigger");

   // Nothing popped unless the request was accepted
   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !accepted |-> (popped_task == '0) && (popped_label == '0))
      else $error("popped fields set on refused request");

endmodule

bind confidence_drift_trigger cdt_checker u_cdt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .accepted       (rsp_ch.accepted),
   .popped_task    (rsp_ch.popped_task),
   .popped_label   (rsp_ch.popped_label),
   .train_request  (rsp_ch.train_request),
   .trigger_reason (rsp_ch.trigger_reason),
   .pending_count  (rsp_ch.pending_count)
);

// File: dv/cdt_trigger_checker.sv
// Result checker for the confidence drift trigger: watches the request,
// result and register channels, predicts every result and compares it.
// Depends on cdt_pkg and the channel interfaces in cdt_channels.sv.
module cdt_trigger_checker (
   input  logic clock,
   input  logic reset,
   cdt_req_if   req_mon,
   cdt_rsp_if   rsp_mon,
   cdt_csr_if   csr_mon,
   output int   fail_count,
   output int   awaiting,
   output int   results_checked,
   output int   drift_triggers
);
   import cdt_pkg::*;

   localparam int          LANES              = 3;
   localparam int          DEPTH              = RING_DEPTH;
   localparam logic [16:0] ALPHA_AT_RESET     = 17'd6554;
   localparam logic [16:0] THRESHOLD_AT_RESET = 17'd39322;
   localparam logic [15:0] INTERVAL_AT_RESET  = 16'd100;
   localparam logic [16:0] AVG_START          = 17'd65536;
   localparam logic [16:0] AVG_CEILING        = 17'h1FFFF;
   localparam logic [7:0]  COUNTER_CAP        = 8'd255;
   localparam logic [15:0] WINDOWS_CAP        = 16'hFFFF;
   localparam logic [7:0]  LAST_TASK          = 8'd2;
   localparam int          WARMUP_WINDOWS     = 10;
   localparam int          HOLD_WINDOWS       = 3;
   localparam int          REPORT_LIMIT       = 10;

   // register copies
   logic [16:0] alpha;
   logic [16:0] threshold;
   logic [15:0] interval;

   // lane and ring state
   logic [16:0] avg       [LANES];
   logic [7:0]  seen      [LANES];
   logic        in_drift  [LANES];
   logic [7:0]  drift_len [LANES];
   logic [1:0]  ring_task  [DEPTH];
   logic [7:0]  ring_label [DEPTH];
   int          wr_ptr;
   int          rd_ptr;
   int          held;
   logic [15:0] windows_total;

   rsp_type awaited_rsp [$];

   // avg + (alpha * (conf - avg)) >>> 16, clamped to the 17-bit range
   function automatic logic [16:0] smoothed_conf(logic [16:0] prev, logic [16:0] conf);
      longint delta;
      longint scaled;
      longint nxt;
      delta  = longint'(conf) - longint'(prev);
      scaled = longint'(alpha) * delta;
      nxt    = longint'(prev) + (scaled >>> 16);
      if (nxt < 0) return '0;
      if (nxt > longint'(AVG_CEILING)) return AVG_CEILING;
      return nxt[16:0];
   endfunction

   function automatic rsp_type advance_trigger(op_type op, logic wv, logic [16:0] conf_a,
                                               logic [16:0] conf_s, logic [16:0] conf_r,
                                               logic [7:0] corr_t, logic [7:0] corr_l);
      rsp_type     res;
      logic [16:0] conf [LANES];
      logic        any_held;
      res     = '0;
      conf[0] = conf_a;
      conf[1] = conf_s;
      conf[2] = conf_r;
      case (op)
         OP_WINDOW: begin
            res.accepted = 1'b1;
            if (wv) begin
               for (int k = 0; k < LANES; k++) begin
                  avg[k] = smoothed_conf(avg[k], conf[k]);
                  if (seen[k] != COUNTER_CAP) seen[k]++;
                  if (avg[k] < threshold && seen[k] > WARMUP_WINDOWS) begin
                     in_drift[k] = 1'b1;
                     if (drift_len[k] != COUNTER_CAP) drift_len[k]++;
                  end else begin
                     in_drift[k]  = 1'b0;
                     drift_len[k] = '0;
                  end
               end
               if (windows_total != WINDOWS_CAP) windows_total++;
            end
         end
         OP_ADD: begin
            if (corr_t <= LAST_TASK) begin
               ring_task[wr_ptr]  = corr_t[1:0];
               ring_label[wr_ptr] = corr_l;
               wr_ptr = (wr_ptr + 1) % DEPTH;
               // full ring: drop the oldest entry
               if (held < DEPTH) held++;
               else rd_ptr = (rd_ptr + 1) % DEPTH;
               res.accepted = 1'b1;
            end
         end
         OP_POP: begin
            if (held > 0) begin
               res.popped_task  = ring_task[rd_ptr];
               res.popped_label = ring_label[rd_ptr];
               rd_ptr = (rd_ptr + 1) % DEPTH;
               held--;
               res.accepted = 1'b1;
            end
         end
         default: ;
      endcase

      any_held = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         res.drift_flags[k] = in_drift[k];
         if (in_drift[k] && drift_len[k] >= HOLD_WINDOWS) any_held = 1'b1;
      end
      // the periodic branch can never win over a pending correction
      if (held > 0) res.trigger_reason = REASON_USER;
      else if (any_held) res.trigger_reason = REASON_DRIFT;
      else if (windows_total >= interval && held > 0) res.trigger_reason = REASON_PERIODIC;
      else res.trigger_reason = REASON_NONE;
      res.train_request = (res.trigger_reason != REASON_NONE);
      res.pending_count = 5'(held);
      return res;
   endfunction

   task automatic note_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("result %0d: %s expected %0h, got %0h", results_checked, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         alpha           = ALPHA_AT_RESET;
         threshold       = THRESHOLD_AT_RESET;
         interval        = INTERVAL_AT_RESET;
         for (int k = 0; k < LANES; k++) begin
            avg[k]       = AVG_START;
            seen[k]      = '0;
            in_drift[k]  = 1'b0;
            drift_len[k] = '0;
         end
         wr_ptr          = 0;
         rd_ptr          = 0;
         held            = 0;
         windows_total   = '0;
         fail_count      = 0;
         results_checked = 0;
         drift_triggers  = 0;
         awaited_rsp.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_ALPHA:     alpha     = csr_mon.data;
               REG_THRESHOLD: threshold = csr_mon.data;
               REG_INTERVAL:  interval  = csr_mon.data[15:0];
               default: ;
            endcase
         end
         // a result never leaves in the cycle of its own request, so compare before predicting
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.accepted       = rsp_mon.accepted;
            got.popped_task    = rsp_mon.popped_task;
            got.popped_label   = rsp_mon.popped_label;
            got.train_request  = rsp_mon.train_request;
            got.trigger_reason = rsp_mon.trigger_reason;
            got.drift_flags    = rsp_mon.drift_flags;
            got.pending_count  = rsp_mon.pending_count;
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("result with no request outstanding: %h", got);
            end else begin
               want = awaited_rsp.pop_front();
               note_field("accepted", want.accepted, got.accepted);
               note_field("popped_task", want.popped_task, got.popped_task);
               note_field("popped_label", want.popped_label, got.popped_label);
               note_field("train_request", want.train_request, got.train_request);
               note_field("trigger_reason", want.trigger_reason, got.trigger_reason);
               note_field("drift_flags", want.drift_flags, got.drift_flags);
               note_field("pending_count", want.pending_count, got.pending_count);
               if (want.trigger_reason == REASON_DRIFT) drift_triggers++;
               results_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_rsp.push_back(advance_trigger(req_mon.op, req_mon.window_valid,
                                                  req_mon.activity_conf, req_mon.stress_conf,
                                                  req_mon.rhythm_conf, req_mon.corr_task,
                                                  req_mon.corr_label));
      end
      awaiting = awaited_rsp.size();
   end

endmodule

// File: dv/tb_top.sv
// Testbench top for confidence_drift_trigger: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on cdt_pkg, the channel interfaces and cdt_trigger_checker.
module tb_top;
   import cdt_pkg::*;

   // op 3 has no name in the package; the block must ignore it
   localparam op_type      OP_UNUSED     = 2'd3;
   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          PHASE_ITEMS   = 280;
   localparam int          SETTLE_CYCLES = 4;
   localparam logic [16:0] CONF_ONE      = 17'd65536;
   localparam logic [16:0] CONF_TOP      = 17'h1FFFF;
   localparam logic [16:0] ALPHA_DEFAULT = 17'd6554;
   localparam logic [16:0] THRESH_DEFAULT = 17'd39322;

   typedef enum {LEAN_NONE, LEAN_LOW, LEAN_HIGH} lean_type;

   typedef struct packed {
      op_type      op;
      logic        window_valid;
      logic [16:0] activity;
      logic [16:0] stress;
      logic [16:0] rhythm;
      logic [7:0]  corr_task;
      logic [7:0]  corr_label;
   } request_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   awaiting;
   int   results_checked;
   int   drift_triggers;
   int   requests_sent;
   int   settings_applied;
   int   cycle_count;
   bit   no_gaps;

   cdt_req_if req_ch ();
   cdt_rsp_if rsp_ch ();
   cdt_csr_if csr_ch ();

   confidence_drift_trigger u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cdt_trigger_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_mon         (csr_ch),
      .fail_count      (fail_count),
      .awaiting        (awaiting),
      .results_checked (results_checked),
      .drift_triggers  (drift_triggers)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abandon the run if it hangs well beyond the slowest legal schedule.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, awaiting);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result back-pressure: mostly short stalls, now and then a long one, and
   // occasional long stretches with ready held high.
   initial begin
      int stall;
      int burst;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= 1'b1;
         burst = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(30, 120);
         repeat (burst) @(posedge clock);
         case ($urandom_range(0, 99)) inside
            [0:49]:  stall = 0;
            [50:87]: stall = $urandom_range(1, 3);
            default: stall = $urandom_range(8, 40);
         endcase
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Confidence with a lean towards drift or recovery; extremes and
   // out-of-range values turn up in every lean.
   function automatic logic [16:0] pick_conf(lean_type lean);
      case ($urandom_range(0, 19))
         0: return '0;
         1: return CONF_ONE;
         2: return CONF_TOP;
         3: return 17'($urandom_range(0, 131071));
         default: begin
            case (lean)
               LEAN_LOW:  return 17'($urandom_range(0, 36000));
               LEAN_HIGH: return 17'($urandom_range(45000, 65536));
               default:   return 17'($urandom_range(0, 65536));
            endcase
         end
      endcase
   endfunction

   function automatic request_type compose(op_type op, logic wv, logic [16:0] a,
                                           logic [16:0] s, logic [16:0] r,
                                           logic [7:0] t, logic [7:0] l);
      request_type rq;
      rq.op           = op;
      rq.window_valid = wv;
      rq.activity     = a;
      rq.stress       = s;
      rq.rhythm       = r;
      rq.corr_task    = t;
      rq.corr_label   = l;
      return rq;
   endfunction

   // Offer one request after a random gap and hold it until accepted.
   // Called at a rising edge; returns at the edge of the handshake.
   task automatic send_request(request_type rq);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.op            <= rq.op;
      req_ch.window_valid  <= rq.window_valid;
      req_ch.activity_conf <= rq.activity;
      req_ch.stress_conf   <= rq.stress;
      req_ch.rhythm_conf   <= rq.rhythm;
      req_ch.corr_task     <= rq.corr_task;
      req_ch.corr_label    <= rq.corr_label;
      req_ch.valid         <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   // Drop valid and wait until every outstanding result has been compared;
   // the count is only read once the checker has seen the last handshake.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (awaiting != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Write all three registers back to back; valid stays high between them.
   task automatic write_settings(logic [16:0] alpha, logic [16:0] thresh, logic [15:0] period);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= REG_ALPHA;
      csr_ch.data  <= alpha;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.index <= REG_THRESHOLD;
      csr_ch.data  <= thresh;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.index <= REG_INTERVAL;
      csr_ch.data  <= {1'b0, period};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      settings_applied++;
   endtask

   // Random traffic in segments: runs of drifting windows, recoveries, bursts
   // of corrections (often past ring capacity) drained by pops, and noise.
   task automatic run_random(int count);
      int       target;
      int       len;
      int       adds;
      lean_type la;
      lean_type ls;
      lean_type lr;
      target = requests_sent + count;
      while (requests_sent < target) begin
         no_gaps = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 19)) inside
            [0:6]: begin
               // drift: long runs of low confidence, needs more than ten windows
               la  = ($urandom_range(0, 3) == 0) ? LEAN_NONE : LEAN_LOW;
               ls  = ($urandom_range(0, 3) == 0) ? LEAN_NONE : LEAN_LOW;
               lr  = ($urandom_range(0, 3) == 0) ? LEAN_NONE : LEAN_LOW;
               len = $urandom_range(15, 60);
               repeat (len)
                  send_request(compose(OP_WINDOW, $urandom_range(0, 19) != 0,
                                       pick_conf(la), pick_conf(ls), pick_conf(lr),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255))));
            end
            [7:10]: begin
               len = $urandom_range(5, 30);
               repeat (len)
                  send_request(compose(OP_WINDOW, $urandom_range(0, 9) != 0,
                                       pick_conf(LEAN_HIGH), pick_conf(LEAN_HIGH),
                                       pick_conf(LEAN_HIGH), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255))));
            end
            [11:16]: begin
               adds = $urandom_range(1, 22);
               repeat (adds)
                  send_request(compose(OP_ADD, 1'($urandom_range(0, 1)),
                                       17'($urandom_range(0, 131071)),
                                       17'($urandom_range(0, 131071)),
                                       17'($urandom_range(0, 131071)),
                                       ($urandom_range(0, 9) == 0) ?
                                          8'($urandom_range(3, 255)) :
                                          8'($urandom_range(0, 2)),
                                       8'($urandom_range(0, 255))));
               // mostly drain the ring (and pop it empty), otherwise leave some
               len = ($urandom_range(0, 9) < 7) ? adds + $urandom_range(0, 3)
                                                 : $urandom_range(0, adds);
               repeat (len)
                  send_request(compose(OP_POP, 1'($urandom_range(0, 1)),
                                       17'($urandom_range(0, 131071)),
                                       17'($urandom_range(0, 131071)),
                                       17'($urandom_range(0, 131071)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255))));
            end
            default: begin
               len = $urandom_range(5, 20);
               repeat (len)
                  send_request(compose(op_type'($urandom_range(0, 3)),
                                       1'($urandom_range(0, 1)),
                                       17'($urandom_range(0, 131071)),
                                       17'($urandom_range(0, 131071)),
                                       17'($urandom_range(0, 131071)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255))));
            end
         endcase
      end
   endtask

   initial begin
      requests_sent        = 0;
      settings_applied     = 0;
      no_gaps              = 1'b0;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.op            <= OP_WINDOW;
      req_ch.window_valid  <= 1'b0;
      req_ch.activity_conf <= '0;
      req_ch.stress_conf   <= '0;
      req_ch.rhythm_conf   <= '0;
      req_ch.corr_task     <= '0;
      req_ch.corr_label    <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= REG_ALPHA;
      csr_ch.data          <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, invalid and unused-op requests, rejected
      // corrections, popping an empty ring, pops with data.
      send_request(compose(OP_WINDOW, 1'b1, '0, CONF_ONE, CONF_TOP, 8'd0, 8'd0));
      send_request(compose(OP_WINDOW, 1'b1, CONF_TOP, '0, CONF_ONE, 8'hFF, 8'hFF));
      send_request(compose(OP_WINDOW, 1'b0, '0, '0, '0, 8'd0, 8'd0));
      send_request(compose(OP_WINDOW, 1'b0, CONF_TOP, CONF_TOP, CONF_TOP, 8'hFF, 8'hFF));
      send_request(compose(OP_UNUSED, 1'b1, CONF_TOP, CONF_TOP, CONF_TOP, 8'd1, 8'hFF));
      send_request(compose(OP_POP, 1'b1, '0, '0, '0, 8'd0, 8'd0));
      send_request(compose(OP_ADD, 1'b0, '0, '0, '0, 8'd3, 8'hFF));
      send_request(compose(OP_ADD, 1'b1, CONF_TOP, CONF_TOP, CONF_TOP, 8'hFF, 8'd0));
      send_request(compose(OP_ADD, 1'b0, '0, '0, '0, 8'd0, 8'd0));
      send_request(compose(OP_ADD, 1'b0, '0, '0, '0, 8'd2, 8'hFF));
      send_request(compose(OP_ADD, 1'b1, CONF_ONE, CONF_ONE, CONF_ONE, 8'd1, 8'hA5));
      send_request(compose(OP_UNUSED, 1'b0, '0, '0, '0, 8'd0, 8'd0));
      send_request(compose(OP_WINDOW, 1'b1, CONF_ONE, CONF_ONE, CONF_ONE, 8'd0, 8'd0));
      send_request(compose(OP_POP, 1'b0, CONF_TOP, CONF_TOP, CONF_TOP, 8'hFF, 8'hFF));
      send_request(compose(OP_POP, 1'b1, '0, '0, '0, 8'd0, 8'd0));
      send_request(compose(OP_POP, 1'b0, '0, '0, '0, 8'd0, 8'd0));
      send_request(compose(OP_POP, 1'b1, '0, '0, '0, 8'd0, 8'd0));

      run_random(PHASE_ITEMS);
      // full weight and highest threshold: a warmed-up lane drifts unless its confidence is at the top value
      drain();
      write_settings(CONF_ONE, CONF_TOP, 16'd1);
      run_random(PHASE_ITEMS);
      // frozen averages, nothing below the threshold
      drain();
      write_settings('0, '0, 16'hFFFF);
      run_random(PHASE_ITEMS);
      // weight past 1.0 pushes averages into both clamps
      drain();
      write_settings(CONF_TOP, THRESH_DEFAULT, 16'd0);
      run_random(PHASE_ITEMS);
      drain();
      write_settings(17'($urandom_range(1, 65536)), 17'($urandom_range(20000, 60000)),
                     16'($urandom_range(1, 65535)));
      run_random(PHASE_ITEMS);
      drain();
      write_settings(ALPHA_DEFAULT, THRESH_DEFAULT, 16'd100);

      // let any stray result show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("covered %0d requests, %0d results compared, %0d register settings",
               requests_sent, results_checked, settings_applied);
      $display("drift-triggered results: %0d, mismatches: %0d", drift_triggers, fail_count);
      if (fail_count == 0 && awaiting == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: confidence_drift_trigger.f
hdl/cdt_pkg.sv
hdl/cdt_channels.sv
hdl/cdt_lane.sv
hdl/cdt_ring.sv
hdl/cdt_merge.sv
hdl/confidence_drift_trigger.sv
hdl/cdt_checker.sv
dv/cdt_trigger_checker.sv
dv/tb_top.sv
